/* design/box_overlap_suppression_unit_macros.svh */
// assertion macros for the box overlap suppression unit
// used by the port checker, no other dependencies
`ifndef BOX_OVERLAP_SUPPRESSION_UNIT_MACROS_SVH
`define BOX_OVERLAP_SUPPRESSION_UNIT_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define BOSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define BOSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/bosu_pkg.sv */
// shared types, constants and helpers for the box overlap suppression unit
// no dependencies
package bosu_pkg;

  localparam int COORD_BITS    = 12;
  localparam int MAX_BOXES_DEF = 64;
  localparam int SCORE_W       = 16;
  localparam int THR_W         = 16;
  localparam int AREA_W        = 2 * COORD_BITS;
  localparam int KEY_W         = (AREA_W > SCORE_W) ? AREA_W : SCORE_W;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE  = 1'd1;

  localparam logic [THR_W-1:0] OVERLAP_THR_RST = 16'd22938;

  // 0.82 and 0.18 in q16
  localparam logic [15:0] CONTAIN_Q16 = 16'd53740;
  localparam logic [13:0] CENTER_Q16  = 14'd11796;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_x;
    logic [COORD_BITS-1:0] box_y;
    logic [COORD_BITS-1:0] box_w;
    logic [COORD_BITS-1:0] box_h;
    logic [SCORE_W-1:0]    score;
    logic                  last_box;
  } box_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] kept_x;
    logic [COORD_BITS-1:0] kept_y;
    logic [COORD_BITS-1:0] kept_w;
    logic [COORD_BITS-1:0] kept_h;
    logic [SCORE_W-1:0]    kept_score;
    logic                  final_kept;
    logic                  dropped_excess;
  } kept_out_t;

  // one stored box with its precomputed area
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [SCORE_W-1:0]    score;
    logic [AREA_W-1:0]     area;
  } entry_t;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic load_en;
    logic sort_en;
    logic phase;
    logic shift_en;
    logic by_area;
  } cell_ctl_t;

  function automatic logic [KEY_W-1:0] key_of(input entry_t e, input logic by_area);
    key_of = by_area ? KEY_W'(e.area) : KEY_W'(e.score);
  endfunction

endpackage

/* design/bosu_cell.sv */
// one cell of the box chain: holds a box, sorts against its neighbors, shifts out
// depends on bosu_pkg
module bosu_cell #(
  parameter int MAX_BOXES = bosu_pkg::MAX_BOXES_DEF,
  parameter int IDX = 0,
  localparam int CntW = $clog2(MAX_BOXES + 1)
) (
  input  logic               clk,
  input  bosu_pkg::cell_ctl_t ctl,
  input  logic [CntW-1:0]    count,
  input  bosu_pkg::entry_t   load_data,
  input  bosu_pkg::entry_t   left_entry,
  input  bosu_pkg::entry_t   right_entry,
  input  logic               left_lt,
  output logic               lt_out,
  output bosu_pkg::entry_t   entry
);
  import bosu_pkg::*;

  localparam logic [CntW-1:0] IDX_C  = CntW'(IDX);
  localparam logic [CntW-1:0] NEXT_C = CntW'(IDX + 1);
  localparam logic            ODD    = (IDX % 2) == 1;

  entry_t cur;
  logic   left_role;

  assign entry     = cur;
  assign lt_out    = key_of(cur, ctl.by_area) < key_of(right_entry, ctl.by_area);
  assign left_role = (ODD == ctl.phase);

  // load at own slot, compare-exchange with the partner, or shift toward the head
  always_ff @(posedge clk) begin
    if (ctl.load_en && count == IDX_C) begin
      cur <= load_data;
    end else if (ctl.sort_en) begin
      if (left_role && NEXT_C < count && lt_out) begin
        cur <= right_entry;
      end else if (!left_role && IDX_C < count && left_lt) begin
        cur <= left_entry;
      end
    end else if (ctl.shift_en) begin
      cur <= right_entry;
    end
  end

endmodule

/* design/bosu_merge.sv */
// pipelined merge test of a candidate box against one kept box
// depends on bosu_pkg
module bosu_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bosu_pkg::THR_W-1:0] thr,
  input  logic                       b_valid,
  input  bosu_pkg::entry_t           a,
  input  bosu_pkg::entry_t           b,
  output logic                       hit_valid,
  output logic                       hit,
  output logic                       busy
);
  import bosu_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int OW   = CB + 1;
  localparam int CW   = CB + 2;
  localparam int IW   = 2 * OW;
  localparam int SQW  = 2 * CW;
  localparam int D2W  = SQW + 1;
  localparam int UW   = IW + 1;
  localparam int RW   = CB + 14;
  localparam int LW   = IW + 16;
  localparam int TW   = UW + THR_W;
  localparam int MW   = AREA_W + 16;
  localparam int R2W  = 2 * RW;
  localparam int CMPW = ((D2W + 30) > R2W) ? (D2W + 30) : R2W;

  logic v1, v2, v3, v4;

  // stage 1: overlaps, center offsets, largest side
  logic [OW-1:0] xr, yb, ox, oy;
  logic [CB-1:0] xl, yt, s_c;
  logic [CW-1:0] cxa, cxb, cya, cyb, dx_c, dy_c;
  logic          ov_c;

  logic [OW-1:0]     s1_ox, s1_oy;
  logic [CW-1:0]     s1_dx, s1_dy;
  logic [CB-1:0]     s1_s;
  logic [AREA_W-1:0] s1_aa, s1_ab;
  logic              s1_ov;

  always_comb begin
    xl = (a.x > b.x) ? a.x : b.x;
    yt = (a.y > b.y) ? a.y : b.y;
    xr = ((OW'(a.x) + OW'(a.w)) < (OW'(b.x) + OW'(b.w))) ?
         (OW'(a.x) + OW'(a.w)) : (OW'(b.x) + OW'(b.w));
    yb = ((OW'(a.y) + OW'(a.h)) < (OW'(b.y) + OW'(b.h))) ?
         (OW'(a.y) + OW'(a.h)) : (OW'(b.y) + OW'(b.h));
    ov_c = (xr > OW'(xl)) && (yb > OW'(yt));
    ox = xr - OW'(xl);
    oy = yb - OW'(yt);
    cxa = {a.x, 1'b0} + CW'(a.w);
    cxb = {b.x, 1'b0} + CW'(b.w);
    cya = {a.y, 1'b0} + CW'(a.h);
    cyb = {b.y, 1'b0} + CW'(b.h);
    dx_c = (cxa >= cxb) ? (cxa - cxb) : (cxb - cxa);
    dy_c = (cya >= cyb) ? (cya - cyb) : (cyb - cya);
    s_c = (a.w > a.h) ? a.w : a.h;
    if (b.w > s_c) s_c = b.w;
    if (b.h > s_c) s_c = b.h;
  end

  always_ff @(posedge clk) begin
    s1_ox <= ox;
    s1_oy <= oy;
    s1_dx <= dx_c;
    s1_dy <= dy_c;
    s1_s  <= s_c;
    s1_aa <= a.area;
    s1_ab <= b.area;
    s1_ov <= ov_c;
  end

  // stage 2: intersection and squared offsets
  logic [IW-1:0]     s2_inter;
  logic [SQW-1:0]    s2_dx2, s2_dy2;
  logic [CB-1:0]     s2_s;
  logic [AREA_W-1:0] s2_aa, s2_ab;
  logic              s2_ov;

  always_ff @(posedge clk) begin
    s2_inter <= IW'(s1_ox) * IW'(s1_oy);
    s2_dx2   <= SQW'(s1_dx) * SQW'(s1_dx);
    s2_dy2   <= SQW'(s1_dy) * SQW'(s1_dy);
    s2_s     <= s1_s;
    s2_aa    <= s1_aa;
    s2_ab    <= s1_ab;
    s2_ov    <= s1_ov;
  end

  // stage 3: union, smaller area, distance, scaled side
  logic [UW-1:0]     s3_uni;
  logic [AREA_W-1:0] s3_mn;
  logic [D2W-1:0]    s3_d2;
  logic [RW-1:0]     s3_rhs;
  logic [IW-1:0]     s3_inter;
  logic              s3_ov, s3_snz;

  always_ff @(posedge clk) begin
    s3_uni   <= UW'(s2_aa) + UW'(s2_ab) - UW'(s2_inter);
    s3_mn    <= (s2_aa < s2_ab) ? s2_aa : s2_ab;
    s3_d2    <= D2W'(s2_dx2) + D2W'(s2_dy2);
    s3_rhs   <= RW'(CENTER_Q16) * RW'(s2_s);
    s3_inter <= s2_inter;
    s3_ov    <= s2_ov;
    s3_snz   <= s2_s != '0;
  end

  // stage 4: cross products
  logic [LW-1:0]  s4_lhs;
  logic [TW-1:0]  s4_thu;
  logic [MW-1:0]  s4_cmn;
  logic [R2W-1:0] s4_rhs2;
  logic [D2W-1:0] s4_d2;
  logic           s4_ov, s4_snz, s4_unz, s4_mnz;

  always_ff @(posedge clk) begin
    s4_lhs  <= {s3_inter, 16'd0};
    s4_thu  <= TW'(thr) * TW'(s3_uni);
    s4_cmn  <= MW'(CONTAIN_Q16) * MW'(s3_mn);
    s4_rhs2 <= R2W'(s3_rhs) * R2W'(s3_rhs);
    s4_d2   <= s3_d2;
    s4_ov   <= s3_ov;
    s4_snz  <= s3_snz;
    s4_unz  <= s3_uni != '0;
    s4_mnz  <= s3_mn != '0;
  end

  // stage 5: ratio compares and the merge decision
  logic iou, cont, cen;
  logic [63:0]     d2_wide;
  logic [CMPW-1:0] d2_sh, rhs2_c;

  always_comb begin
    d2_wide = 64'(s4_d2);
    d2_sh   = CMPW'({s4_d2, 30'd0});
    rhs2_c  = CMPW'(s4_rhs2);
    iou     = s4_unz && (TW'(s4_lhs) > s4_thu);
    cont    = s4_mnz && (LW'(s4_cmn) < s4_lhs);
    cen     = s4_snz && (d2_wide < 64'h4000_0000) && (d2_sh < rhs2_c);
  end

  always_ff @(posedge clk) begin
    hit <= s4_ov && (iou || (cont && cen));
  end

  // valid bits follow the data through the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      v1 <= b_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      hit_valid <= v4;
    end
  end

  assign busy = v1 | v2 | v3 | v4 | hit_valid;

endmodule

/* design/box_overlap_suppression_unit.sv */
// top level of the box overlap suppression unit: cell chain, kept store, sequencer
// depends on bosu_pkg, bosu_cell, bosu_merge
//
//   port group            direction  handshake
//   box (start, busy)     in         taken when start is high and busy low
//   kept (kept_strobe)    out        one cycle per kept box, no back pressure
//   cfg_we/index/data     in         written at every edge with cfg_we high
//
// loading takes one item per cycle while busy is low
// the item marked last starts a run: odd-even sorting in the chain, then per box a
// fetch, once any box is kept a read of each kept box through the merge pipeline
// and a drain, and a decide step; a flush step ends it
// reset clears counts, flags and the sequencer; no clearing pass
// results cannot be stalled: busy stays high until the final result has been shown
module box_overlap_suppression_unit #(
  parameter int MAX_BOXES = bosu_pkg::MAX_BOXES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  bosu_pkg::box_in_t               box,
  output logic                            kept_strobe,
  output bosu_pkg::kept_out_t             kept,
  input  logic                            cfg_we,
  input  logic [bosu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bosu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bosu_pkg::*;

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam logic [CNT_W-1:0] FULL_C     = CNT_W'(MAX_BOXES);
  localparam logic [CNT_W-1:0] SORT_END_C = CNT_W'(MAX_BOXES - 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SORT   = 7'b0000010,
    ST_FETCH  = 7'b0000100,
    ST_CMP    = 7'b0001000,
    ST_DRAIN  = 7'b0010000,
    ST_DECIDE = 7'b0100000,
    ST_FLUSH  = 7'b1000000
  } state_t;

  state_t state;

  logic [THR_W-1:0] thr;
  logic             by_area;
  logic [CNT_W-1:0] count, sort_cnt, cand_idx, kcnt, rd_idx;
  logic             ovf, hit_acc, pend_valid, rd_v;
  entry_t           cand, pend, rd_data, load_data;
  entry_t           cell_q [MAX_BOXES];
  logic             lt     [MAX_BOXES];
  cell_ctl_t        ctl;
  logic             accept, m_hit_valid, m_hit, m_busy;

  entry_t kept_mem [MAX_BOXES];

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE) || kept_strobe;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr     <= OVERLAP_THR_RST;
      by_area <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OVERLAP_THR: thr     <= cfg_data;
        REG_ORDER_MODE:  by_area <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // incoming item with its area
  always_comb begin
    load_data.x     = box.box_x;
    load_data.y     = box.box_y;
    load_data.w     = box.box_w;
    load_data.h     = box.box_h;
    load_data.score = box.score;
    load_data.area  = AREA_W'(box.box_w) * AREA_W'(box.box_h);
  end

  // chain controls
  always_comb begin
    ctl.load_en  = accept && (count < FULL_C);
    ctl.sort_en  = state == ST_SORT;
    ctl.phase    = sort_cnt[0];
    ctl.shift_en = state == ST_FETCH;
    ctl.by_area  = by_area;
  end

  // the chain of cells
  for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_lt;
    if (g == 0) begin : g_head
      assign left_e  = '0;
      assign left_lt = 1'b0;
    end else begin : g_mid
      assign left_e  = cell_q[g-1];
      assign left_lt = lt[g-1];
    end
    if (g == MAX_BOXES - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cell_q[g+1];
    end
    bosu_cell #(
      .MAX_BOXES(MAX_BOXES),
      .IDX(g)
    ) u_cell (
      .clk(clk),
      .ctl(ctl),
      .count(count),
      .load_data(load_data),
      .left_entry(left_e),
      .right_entry(right_e),
      .left_lt(left_lt),
      .lt_out(lt[g]),
      .entry(cell_q[g])
    );
  end

  // kept box store, one write or one read a cycle
  always_ff @(posedge clk) begin
    if (state == ST_DECIDE && !hit_acc) begin
      kept_mem[kcnt[IDX_W-1:0]] <= cand;
    end
    if (state == ST_CMP) begin
      rd_data <= kept_mem[rd_idx[IDX_W-1:0]];
    end
  end

  bosu_merge u_merge (
    .clk(clk),
    .rst(rst),
    .thr(thr),
    .b_valid(rd_v),
    .a(cand),
    .b(rd_data),
    .hit_valid(m_hit_valid),
    .hit(m_hit),
    .busy(m_busy)
  );

  // candidate and pending result payload
  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      cand <= cell_q[0];
    end
    if (state == ST_DECIDE && !hit_acc) begin
      pend <= cand;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      ovf         <= 1'b0;
      sort_cnt    <= '0;
      cand_idx    <= '0;
      kcnt        <= '0;
      rd_idx      <= '0;
      rd_v        <= 1'b0;
      hit_acc     <= 1'b0;
      pend_valid  <= 1'b0;
      kept_strobe <= 1'b0;
    end else begin
      kept_strobe <= (state == ST_DECIDE && !hit_acc && pend_valid) || state == ST_FLUSH;
      rd_v        <= state == ST_CMP;
      if (state == ST_FETCH) begin
        hit_acc <= 1'b0;
      end else if (m_hit_valid && m_hit) begin
        hit_acc <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count < FULL_C) begin
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (box.last_box) begin
              sort_cnt <= '0;
              state    <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          sort_cnt <= sort_cnt + 1'b1;
          if (sort_cnt == SORT_END_C) begin
            cand_idx <= '0;
            state    <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          cand_idx <= cand_idx + 1'b1;
          rd_idx   <= '0;
          state    <= (kcnt == '0) ? ST_DECIDE : ST_CMP;
        end
        ST_CMP: begin
          rd_idx <= rd_idx + 1'b1;
          if (rd_idx == kcnt - 1'b1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v && !m_busy) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (!hit_acc) begin
            kcnt       <= kcnt + 1'b1;
            pend_valid <= 1'b1;
          end
          state <= (cand_idx == count) ? ST_FLUSH : ST_FETCH;
        end
        ST_FLUSH: begin
          pend_valid  <= 1'b0;
          count       <= '0;
          ovf         <= 1'b0;
          kcnt        <= '0;
          state       <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result payload: the older pending box leaves when a newer one is kept or at the flush
  always_ff @(posedge clk) begin
    if ((state == ST_DECIDE && !hit_acc && pend_valid) || state == ST_FLUSH) begin
      kept.kept_x         <= pend.x;
      kept.kept_y         <= pend.y;
      kept.kept_w         <= pend.w;
      kept.kept_h         <= pend.h;
      kept.kept_score     <= pend.score;
      kept.final_kept     <= state == ST_FLUSH;
      kept.dropped_excess <= ovf;
    end
  end

endmodule

/* design/bosu_checker.sv */
// port-level checker for the box overlap suppression unit, bound to the top level
// depends on bosu_pkg and box_overlap_suppression_unit_macros.svh
`include "box_overlap_suppression_unit_macros.svh"

module bosu_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input bosu_pkg::box_in_t   box,
  input logic                kept_strobe,
  input bosu_pkg::kept_out_t kept
);
  import bosu_pkg::*;

  // a result only shows while the unit reports busy
  `BOSU_ASSERT_NOW(a_strobe_busy, kept_strobe, busy, "result shown while not busy")

  // a plain item never produces a result in the next cycle
  `BOSU_ASSERT_NEXT(a_no_early, start && !busy && !box.last_box, !kept_strobe,
                    "result right after a plain item")

  // the last item of a set starts a run
  `BOSU_ASSERT_NEXT(a_run_starts, start && !busy && box.last_box, busy,
                    "run did not start on last item")

  // the final result closes the run
  `BOSU_ASSERT_NEXT(a_final_ends, kept_strobe && kept.final_kept, !busy && !kept_strobe,
                    "activity after final result")

endmodule

bind box_overlap_suppression_unit bosu_checker u_bosu_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .box(box),
  .kept_strobe(kept_strobe),
  .kept(kept)
);

/* tb/tb_box_overlap_suppression_unit.sv */
// testbench for box_overlap_suppression_unit: drives box sets and register writes,
// predicts the kept boxes with a scoreboard class; depends on bosu_pkg and the rtl
module tb_box_overlap_suppression_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bosu_pkg::*;

  // greedy suppression predictor and queue of expected kept boxes
  class nms_scoreboard;
    box_in_t   loaded[$];
    kept_out_t kept_q[$];
    bit        overflow;
    logic [THR_W-1:0] thr = OVERLAP_THR_RST;
    bit        by_area;
    int        errors;

    function longint unsigned key_of_box(box_in_t b);
      if (by_area) return longint'(b.box_w) * longint'(b.box_h);
      return longint'(b.score);
    endfunction

    function bit overlaps(box_in_t a, box_in_t b);
      longint unsigned ax, ay, aw, ah, bx, by, bw, bh;
      longint unsigned xl, yt, xr, yb, aa, ab, inter, uni, mn, s, dx, dy, d2, rhs;
      longint sdx, sdy;
      ax = a.box_x; ay = a.box_y; aw = a.box_w; ah = a.box_h;
      bx = b.box_x; by = b.box_y; bw = b.box_w; bh = b.box_h;
      xl = (ax > bx) ? ax : bx;
      yt = (ay > by) ? ay : by;
      xr = (ax + aw < bx + bw) ? ax + aw : bx + bw;
      yb = (ay + ah < by + bh) ? ay + ah : by + bh;
      aa = aw * ah;
      ab = bw * bh;
      if (xr <= xl || yb <= yt) return 0;
      inter = (xr - xl) * (yb - yt);
      uni = aa + ab - inter;
      if (uni > 0 && (inter << 16) > longint'(thr) * uni) return 1;
      mn = (aa < ab) ? aa : ab;
      if (mn == 0 || !((inter << 16) > longint'(CONTAIN_Q16) * mn)) return 0;
      s = aw;
      if (ah > s) s = ah;
      if (bw > s) s = bw;
      if (bh > s) s = bh;
      if (s == 0) return 0;
      sdx = longint'(2 * ax + aw) - longint'(2 * bx + bw);
      sdy = longint'(2 * ay + ah) - longint'(2 * by + bh);
      dx = (sdx < 0) ? -sdx : sdx;
      dy = (sdy < 0) ? -sdy : sdy;
      d2 = dx * dx + dy * dy;
      if (d2 >= (64'd1 << 30)) return 0;
      rhs = longint'(CENTER_Q16) * s;
      return (d2 << 30) < rhs * rhs;
    endfunction

    // note an accepted item; a last mark sorts, suppresses and queues the kept boxes
    function void note_box(box_in_t b);
      int ord[MAX_BOXES_DEF];
      box_in_t keep[$];
      int n, j;
      bit hit;
      longint unsigned k;
      kept_out_t r;
      if (loaded.size() < MAX_BOXES_DEF) loaded.insert(loaded.size(), b);
      else overflow = 1;
      if (!b.last_box) return;
      n = loaded.size();
      // stable insertion sort, descending key
      for (int i = 0; i < n; i++) begin
        k = key_of_box(loaded[i]);
        j = i;
        while (j > 0 && key_of_box(loaded[ord[j-1]]) < k) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = i;
      end
      for (int i = 0; i < n; i++) begin
        hit = 0;
        foreach (keep[m]) if (!hit && overlaps(loaded[ord[i]], keep[m])) hit = 1;
        if (!hit) keep.insert(keep.size(), loaded[ord[i]]);
      end
      foreach (keep[m]) begin
        r.kept_x = keep[m].box_x;
        r.kept_y = keep[m].box_y;
        r.kept_w = keep[m].box_w;
        r.kept_h = keep[m].box_h;
        r.kept_score = keep[m].score;
        r.final_kept = (m == keep.size() - 1);
        r.dropped_excess = overflow;
        kept_q.insert(kept_q.size(), r);
      end
      loaded.delete();
      overflow = 0;
    endfunction

    // compare one kept box with the oldest expectation
    function void check_kept(kept_out_t a);
      kept_out_t e;
      if (kept_q.size() == 0) begin
        $error("kept box with none expected: %p", a);
        errors++;
        return;
      end
      e = kept_q.pop_front();
      if (a.kept_x !== e.kept_x) begin
        $error("kept_x expected %0d actual %0d", e.kept_x, a.kept_x); errors++;
      end
      if (a.kept_y !== e.kept_y) begin
        $error("kept_y expected %0d actual %0d", e.kept_y, a.kept_y); errors++;
      end
      if (a.kept_w !== e.kept_w) begin
        $error("kept_w expected %0d actual %0d", e.kept_w, a.kept_w); errors++;
      end
      if (a.kept_h !== e.kept_h) begin
        $error("kept_h expected %0d actual %0d", e.kept_h, a.kept_h); errors++;
      end
      if (a.kept_score !== e.kept_score) begin
        $error("kept_score expected %0d actual %0d", e.kept_score, a.kept_score); errors++;
      end
      if (a.final_kept !== e.final_kept) begin
        $error("final_kept expected %0d actual %0d", e.final_kept, a.final_kept); errors++;
      end
      if (a.dropped_excess !== e.dropped_excess) begin
        $error("dropped_excess expected %0d actual %0d", e.dropped_excess,
               a.dropped_excess);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  box_in_t box = '0;
  logic kept_strobe;
  kept_out_t kept;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nms_scoreboard sb = new();
  int quiet_cycles;
  box_in_t base;

  box_overlap_suppression_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .box(box),
    .kept_strobe(kept_strobe), .kept(kept),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // results sampled mid-cycle, away from the driving edge
  always @(negedge clk) begin
    if (!rst && kept_strobe) begin
      sb.check_kept(kept);
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on cycles without any item or result moving
  always @(negedge clk) begin
    if (quiet_cycles > 60000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // hand one item over, idling now and then before it
  task automatic send_box(box_in_t b, bit may_idle);
    if (may_idle && $urandom_range(99) < 8) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    box <= b;
    start <= 1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sb.note_box(b);
    quiet_cycles <= 0;
  endtask

  // stop sending and wait for the block to drain
  task automatic drain();
    start <= 0;
    do @(negedge clk); while (sb.kept_q.size() != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_OVERLAP_THR) sb.thr = val;
    else sb.by_area = val[0];
  endtask

  function automatic box_in_t mk(int x, int y, int w, int h, int s, bit l);
    box_in_t b;
    b.box_x = COORD_BITS'(x); b.box_y = COORD_BITS'(y);
    b.box_w = COORD_BITS'(w); b.box_h = COORD_BITS'(h);
    b.score = SCORE_W'(s); b.last_box = l;
    return b;
  endfunction

  // random box: mostly jittered around a per-set base, sometimes anything
  function automatic box_in_t rand_box(box_in_t c, bit l);
    box_in_t b;
    int j;
    b = c;
    j = $urandom_range(99);
    if (j < 15) begin
      b = box_in_t'({$urandom, $urandom, 1'b0});
    end else begin
      b.box_x = COORD_BITS'(c.box_x + $urandom_range(0, 8) - 4);
      b.box_y = COORD_BITS'(c.box_y + $urandom_range(0, 8) - 4);
      b.box_w = COORD_BITS'(c.box_w + $urandom_range(0, 6) - 3);
      b.box_h = COORD_BITS'(c.box_h + $urandom_range(0, 6) - 3);
      b.score = (j < 30) ? 16'($urandom_range(0, 3) * 1000) : 16'($urandom);
      if (j > 95) b.box_w = '0;
    end
    b.last_box = l;
    return b;
  endfunction

  task automatic rand_sets(int items, int max_size);
    int sent, sz;
    sent = 0;
    while (sent < items) begin
      sz = $urandom_range(1, max_size);
      base = mk($urandom_range(0, 4000), $urandom_range(0, 4000),
                $urandom_range(4, 200), $urandom_range(4, 200), 0, 0);
      for (int i = 0; i < sz; i++) send_box(rand_box(base, i == sz - 1), 1'b1);
      sent += sz;
    end
  endtask

  initial begin
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: single box at the extremes
    send_box(mk(4095, 4095, 4095, 4095, 65535, 1), 0);
    send_box(mk(0, 0, 0, 0, 0, 1), 0);
    // identical boxes merge by iou, tie keeps arrival order
    send_box(mk(100, 100, 50, 50, 500, 0), 0);
    send_box(mk(100, 100, 50, 50, 500, 0), 0);
    send_box(mk(300, 300, 50, 50, 900, 1), 0);
    // small box inside a big one: containment with near centers
    send_box(mk(1000, 1000, 100, 100, 40000, 0), 0);
    send_box(mk(1005, 1005, 90, 90, 30000, 0), 0);
    // zero-area box sitting on top of a kept one
    send_box(mk(1000, 1000, 0, 100, 20000, 0), 0);
    // touching edges, no overlap
    send_box(mk(1100, 1000, 100, 100, 10000, 1), 0);

    write_reg(REG_ORDER_MODE, 16'd1);
    send_box(mk(10, 10, 20, 20, 65535, 0), 0);
    send_box(mk(12, 12, 60, 60, 1, 0), 0);
    send_box(mk(2000, 2000, 4095, 4095, 7, 1), 0);
    write_reg(REG_OVERLAP_THR, 16'd0);
    send_box(mk(10, 10, 20, 20, 5, 0), 0);
    send_box(mk(29, 29, 20, 20, 6, 1), 0);
    write_reg(REG_OVERLAP_THR, 16'd65535);
    send_box(mk(10, 10, 20, 20, 5, 0), 0);
    send_box(mk(10, 10, 20, 20, 6, 1), 0);

    // random phases over several register settings
    write_reg(REG_ORDER_MODE, 16'd0);
    write_reg(REG_OVERLAP_THR, OVERLAP_THR_RST);
    rand_sets(8, 6);
    write_reg(REG_OVERLAP_THR, 16'($urandom));
    rand_sets(6, 6);
    write_reg(REG_ORDER_MODE, 16'd1);
    write_reg(REG_OVERLAP_THR, 16'($urandom_range(0, 20000)));
    rand_sets(6, 6);
    write_reg(REG_ORDER_MODE, 16'd0);
    write_reg(REG_OVERLAP_THR, 16'd65535);
    rand_sets(5, 5);

    // store full: one extra box, marked last, is dropped
    drain();
    write_reg(REG_OVERLAP_THR, 16'd0);
    base = mk(200, 200, 40, 40, 0, 0);
    for (int i = 0; i <= MAX_BOXES_DEF; i++) send_box(rand_box(base, i == MAX_BOXES_DEF), 0);
    // next set must show the flag cleared
    send_box(mk(7, 7, 7, 7, 7, 1), 0);

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.kept_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+design
design/bosu_pkg.sv
design/bosu_cell.sv
design/bosu_merge.sv
design/box_overlap_suppression_unit.sv
design/bosu_checker.sv
tb/tb_box_overlap_suppression_unit.sv
